[hw/rtl/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and widths for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

  // element format
  localparam int DW   = 32;
  localparam int FB   = 16;
  // lanes: one per inverse entry
  localparam int NL   = 9;
  // exact intermediate widths
  localparam int PW   = 2 * DW;
  localparam int CW   = PW + 1;
  localparam int DETW = 3 * DW + 3;
  localparam int NW   = CW + 2 * FB;
  // quotient bits kept before the overflow check decides
  localparam int QB   = DW + 1;
  localparam int MW   = QB + 1;
  localparam int RW   = (NW > DETW + QB) ? NW : DETW + QB;
  // divider stages: one per quotient bit plus rounding
  localparam int NDS  = QB + 1;

  typedef logic signed [DW-1:0] elem_t;
  typedef logic [NW-1:0]        num_t;
  typedef logic [DETW-1:0]      den_t;
  typedef logic [MW-1:0]        mag_t;

  typedef struct packed {
    elem_t m00; elem_t m01; elem_t m02;
    elem_t m10; elem_t m11; elem_t m12;
    elem_t m20; elem_t m21; elem_t m22;
  } in_t;

  typedef struct packed {
    elem_t r00; elem_t r01; elem_t r02;
    elem_t r10; elem_t r11; elem_t r12;
    elem_t r20; elem_t r21; elem_t r22;
    logic  singular;
    logic  saturated;
  } out_t;

  // per-item flags that ride alongside the divider
  typedef struct packed {
    logic [NL-1:0] neg;
    logic          zero;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/m3i_in_if.sv]
// ----------------------------------------------------------------------------
// m3i_in_if
// Matrix input channel: valid, ready and nine elements.
// ----------------------------------------------------------------------------
`default_nettype none

interface m3i_in_if;
  logic          valid;
  logic          ready;
  m3i_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/m3i_out_if.sv]
// ----------------------------------------------------------------------------
// m3i_out_if
// Inverse result channel: valid, ready, nine entries and two flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface m3i_out_if;
  logic          valid;
  logic          ready;
  m3i_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/m3i_div.sv]
// ----------------------------------------------------------------------------
// m3i_div
// Nine-lane pipelined restoring divider, one quotient bit per stage, with
// a shared divisor, an overflow check and a final round-half-up stage.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_div (
  input  wire logic                               clk_i,
  input  wire logic [m3i_pkg::NDS-1:0]            en_i,
  input  wire m3i_pkg::num_t [m3i_pkg::NL-1:0]    num_i,
  input  wire m3i_pkg::den_t                      den_i,
  output m3i_pkg::mag_t [m3i_pkg::NL-1:0]         mag_o,
  output logic [m3i_pkg::NL-1:0]                  ovf_o
);
  import m3i_pkg::*;

  logic [RW-1:0] rem_in [QB][NL];
  logic [QB-1:0] quo_in [QB][NL];
  logic          ovf_in [QB][NL];
  den_t          den_in [QB];

  logic [RW-1:0] rem_d  [QB][NL];
  logic [QB-1:0] quo_d  [QB][NL];

  logic [RW-1:0] rem_q  [QB][NL];
  logic [QB-1:0] quo_q  [QB][NL];
  logic          ovf_q  [QB][NL];
  den_t          den_q  [QB];

  mag_t          mag_d  [NL];
  mag_t          mag_q  [NL];
  logic [NL-1:0] ovfr_q;

  for (genvar s = 0; s < QB; s++) begin : g_st
    logic [RW-1:0] dsh;

    // stage inputs: the first stage takes the operands and checks overflow
    if (s == 0) begin : g_head
      assign den_in[s] = den_i;
      for (genvar l = 0; l < NL; l++) begin : g_l
        assign rem_in[s][l] = RW'(num_i[l]);
        assign quo_in[s][l] = '0;
        assign ovf_in[s][l] = RW'(num_i[l]) >= (RW'(den_i) << QB);
      end
    end else begin : g_body
      assign den_in[s] = den_q[s-1];
      for (genvar l = 0; l < NL; l++) begin : g_l
        assign rem_in[s][l] = rem_q[s-1][l];
        assign quo_in[s][l] = quo_q[s-1][l];
        assign ovf_in[s][l] = ovf_q[s-1][l];
      end
    end

    // divisor aligned to this stage's quotient bit
    assign dsh = RW'(den_in[s]) << (QB - 1 - s);

    // compare and subtract, one bit per lane
    for (genvar l = 0; l < NL; l++) begin : g_cs
      logic take;
      assign take        = rem_in[s][l] >= dsh;
      assign rem_d[s][l] = take ? rem_in[s][l] - dsh : rem_in[s][l];
      assign quo_d[s][l] = {quo_in[s][l][QB-2:0], take};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        den_q[s] <= den_in[s];
        for (int l = 0; l < NL; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          quo_q[s][l] <= quo_d[s][l];
          ovf_q[s][l] <= ovf_in[s][l];
        end
      end
    end
  end

  // round to nearest: bump when twice the remainder reaches the divisor
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      mag_d[l] = MW'(quo_q[QB-1][l]) +
                 MW'({rem_q[QB-1][l], 1'b0} >= (RW+1)'(den_q[QB-1]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[QB]) begin
      for (int l = 0; l < NL; l++) begin
        mag_q[l]  <= mag_d[l];
        ovfr_q[l] <= ovf_q[QB-1][l];
      end
    end
  end

  // outputs
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      mag_o[l] = mag_q[l];
    end
  end
  assign ovf_o = ovfr_q;

endmodule

`default_nettype wire

[hw/rtl/matrix3x3_inverse.sv]
// Pipeline: 41 register stages (6 arithmetic, 34 divider, 1 output).
// Throughput: one matrix per cycle while the output is not stalled;
// the bit-per-stage divider sets depth.
// Stalls propagate stage by stage; empty stages keep accepting.
// Reset clears only the stage valid bits; no other state.
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined 3x3 inverse by adjugate over exact determinant, Q16.16 with
// rounding, saturation and singular detection.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  m3i_in_if.sink     in_i,
  m3i_out_if.source  out_o
);
  import m3i_pkg::*;

  localparam int S_PRD  = 0;
  localparam int S_COF  = 1;
  localparam int S_DTP  = 2;
  localparam int S_DTT  = 3;
  localparam int S_DET  = 4;
  localparam int S_ABS  = 5;
  localparam int S_DIV0 = 6;
  localparam int S_OUT  = S_DIV0 + NDS;
  localparam int NST    = S_OUT + 1;
  localparam int LW     = 2 * DW + 1;

  function automatic logic signed [PW-1:0] smul(elem_t x, elem_t y);
    return $signed({{DW{x[DW-1]}}, x}) * $signed({{DW{y[DW-1]}}, y});
  endfunction

  // stage handshake
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // element view of the input
  elem_t el [9];
  assign el[0] = in_i.data.m00; assign el[1] = in_i.data.m01;
  assign el[2] = in_i.data.m02; assign el[3] = in_i.data.m10;
  assign el[4] = in_i.data.m11; assign el[5] = in_i.data.m12;
  assign el[6] = in_i.data.m20; assign el[7] = in_i.data.m21;
  assign el[8] = in_i.data.m22;

  // stage 1: eighteen 2x2 products
  logic signed [PW-1:0] prod_q [18];
  elem_t                abc1_q [3];

  always_ff @(posedge clk_i) begin
    if (en[S_PRD]) begin
      prod_q[0]  <= smul(el[4], el[8]); prod_q[1]  <= smul(el[5], el[7]);
      prod_q[2]  <= smul(el[2], el[7]); prod_q[3]  <= smul(el[1], el[8]);
      prod_q[4]  <= smul(el[1], el[5]); prod_q[5]  <= smul(el[2], el[4]);
      prod_q[6]  <= smul(el[5], el[6]); prod_q[7]  <= smul(el[3], el[8]);
      prod_q[8]  <= smul(el[0], el[8]); prod_q[9]  <= smul(el[2], el[6]);
      prod_q[10] <= smul(el[2], el[3]); prod_q[11] <= smul(el[0], el[5]);
      prod_q[12] <= smul(el[3], el[7]); prod_q[13] <= smul(el[4], el[6]);
      prod_q[14] <= smul(el[1], el[6]); prod_q[15] <= smul(el[0], el[7]);
      prod_q[16] <= smul(el[0], el[4]); prod_q[17] <= smul(el[1], el[3]);
      for (int t = 0; t < 3; t++) abc1_q[t] <= el[t];
    end
  end

  // stage 2: adjugate entries
  logic signed [CW-1:0] cof_q  [NL];
  elem_t                abc2_q [3];

  always_ff @(posedge clk_i) begin
    if (en[S_COF]) begin
      for (int k = 0; k < NL; k++) begin
        cof_q[k] <= $signed({prod_q[2*k][PW-1], prod_q[2*k]}) -
                    $signed({prod_q[2*k+1][PW-1], prod_q[2*k+1]});
      end
      for (int t = 0; t < 3; t++) abc2_q[t] <= abc1_q[t];
    end
  end

  // stage 3: determinant partial products, adjugate magnitudes
  logic signed [LW-1:0] lo_q [3];
  logic signed [LW-1:0] hi_q [3];
  logic [CW-1:0]        amag3_q [NL];
  logic [NL-1:0]        aneg3_q;
  logic signed [CW-1:0] dcof [3];

  assign dcof[0] = cof_q[0];
  assign dcof[1] = cof_q[3];
  assign dcof[2] = cof_q[6];

  always_ff @(posedge clk_i) begin
    if (en[S_DTP]) begin
      for (int t = 0; t < 3; t++) begin
        lo_q[t] <= $signed({{(DW+1){abc2_q[t][DW-1]}}, abc2_q[t]}) *
                   $signed({{(DW+1){1'b0}}, dcof[t][DW-1:0]});
        hi_q[t] <= $signed({{(DW+1){abc2_q[t][DW-1]}}, abc2_q[t]}) *
                   $signed({{DW{dcof[t][CW-1]}}, dcof[t][CW-1:DW]});
      end
      for (int k = 0; k < NL; k++) begin
        amag3_q[k] <= cof_q[k][CW-1] ? CW'(-cof_q[k]) : CW'(cof_q[k]);
        aneg3_q[k] <= cof_q[k][CW-1];
      end
    end
  end

  // stage 4: recombine partial products into three terms
  logic signed [DETW-1:0] term_q [3];
  logic [CW-1:0]          amag4_q [NL];
  logic [NL-1:0]          aneg4_q;

  always_ff @(posedge clk_i) begin
    if (en[S_DTT]) begin
      for (int t = 0; t < 3; t++) begin
        term_q[t] <= ($signed({{(DETW-LW){hi_q[t][LW-1]}}, hi_q[t]}) <<< DW) +
                     $signed({{(DETW-LW){lo_q[t][LW-1]}}, lo_q[t]});
      end
      amag4_q <= amag3_q;
      aneg4_q <= aneg3_q;
    end
  end

  // stage 5: determinant
  logic signed [DETW-1:0] det_q;
  logic [CW-1:0]          amag5_q [NL];
  logic [NL-1:0]          aneg5_q;

  always_ff @(posedge clk_i) begin
    if (en[S_DET]) begin
      det_q   <= term_q[0] + term_q[1] + term_q[2];
      amag5_q <= amag4_q;
      aneg5_q <= aneg4_q;
    end
  end

  // stage 6: divider operands and result signs
  den_t               den6_q;
  num_t [NL-1:0]      num6_q;
  side_t              side6_q;

  always_ff @(posedge clk_i) begin
    if (en[S_ABS]) begin
      den6_q       <= det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);
      side6_q.zero <= (det_q == '0);
      for (int k = 0; k < NL; k++) begin
        num6_q[k]       <= {amag5_q[k], {(2*FB){1'b0}}};
        side6_q.neg[k]  <= aneg5_q[k] ^ det_q[DETW-1];
      end
    end
  end

  // divider lanes
  mag_t [NL-1:0] mag;
  logic [NL-1:0] ovf;

  m3i_div u_div (
    .clk_i (clk_i),
    .en_i  (en[S_DIV0 +: NDS]),
    .num_i (num6_q),
    .den_i (den6_q),
    .mag_o (mag),
    .ovf_o (ovf)
  );

  // flags follow the divider stages
  side_t side_q [NDS];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NDS; s++) begin
      if (en[S_DIV0 + s]) side_q[s] <= (s == 0) ? side6_q : side_q[(s == 0) ? 0 : s - 1];
    end
  end

  // output stage: saturate, apply sign, handle singular
  elem_t res [NL];
  logic  sat_any;
  side_t sd;

  assign sd = side_q[NDS-1];

  always_comb begin
    mag_t          lim;
    logic [DW-1:0] low;
    logic          sat;
    sat_any = 1'b0;
    for (int l = 0; l < NL; l++) begin
      lim = (MW'(1) << (DW - 1)) - MW'(!sd.neg[l]);
      low = mag[l][DW-1:0];
      sat = ovf[l] || (mag[l] > lim);
      if (sd.zero) begin
        res[l] = '0;
      end else if (sat) begin
        res[l] = sd.neg[l] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        res[l] = sd.neg[l] ? ~low + DW'(1) : low;
      end
      sat_any = sat_any || (sat && !sd.zero);
    end
  end

  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      out_q.r00       <= res[0]; out_q.r01 <= res[1]; out_q.r02 <= res[2];
      out_q.r10       <= res[3]; out_q.r11 <= res[4]; out_q.r12 <= res[5];
      out_q.r20       <= res[6]; out_q.r21 <= res[7]; out_q.r22 <= res[8];
      out_q.singular  <= sd.zero;
      out_q.saturated <= sat_any;
    end
  end

  assign out_o.valid = v_q[NST-1];
  assign out_o.data  = out_q;

  // checks
  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.singular |-> !out_o.data.saturated)
    else $error("singular result flagged saturated");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.singular |->
      out_o.data.r00 == '0 && out_o.data.r11 == '0 && out_o.data.r22 == '0)
    else $error("singular result with nonzero entries");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NST-1] |-> in_i.ready)
    else $error("input stalled with empty output stage");

endmodule

`default_nettype wire

[tb/sv/tb_matrix3x3_inverse.sv]
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Self-checking bench for the pipelined 3x3 inverse: directed corner
// matrices, then random matrices under several idle and stall mixes, each
// result checked field by field against an exact adjugate predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix3x3_inverse;
  import m3i_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int RandPerPhase = 437;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 60;

  logic clk_i = 1'b0;
  logic rst_ni;

  m3i_in_if  in_ch ();
  m3i_out_if out_ch ();

  matrix3x3_inverse dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // clock
  always #1 clk_i = ~clk_i;

  out_t inverse_q[$];
  int   idle_pct;
  int   stall_pct;
  int   mismatches;
  int   cycles;

  // rounded, saturated quotient; bit 32 flags clipping
  function automatic logic [32:0] round_quot(wide_t n, wide_t d);
    logic         neg;
    logic [255:0] un, ud, q, r;
    logic [255:0] lim;
    neg = n[255] ^ d[255];
    un  = n[255] ? -n : n;
    ud  = d[255] ? -d : d;
    q   = un / ud;
    r   = un % ud;
    if ((r << 1) >= ud) q = q + 1;
    lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
    if (q > lim) return {1'b1, neg ? 32'h8000_0000 : 32'h7fff_ffff};
    return {1'b0, neg ? -q[31:0] : q[31:0]};
  endfunction

  // exact adjugate over determinant
  function automatic out_t predict_inverse(in_t m);
    wide_t a, b, c, d, e, f, g, h, i;
    wide_t adj[9];
    wide_t det;
    logic [32:0] qv[9];
    out_t  res;
    logic  sat;
    a = wide_t'(m.m00); b = wide_t'(m.m01); c = wide_t'(m.m02);
    d = wide_t'(m.m10); e = wide_t'(m.m11); f = wide_t'(m.m12);
    g = wide_t'(m.m20); h = wide_t'(m.m21); i = wide_t'(m.m22);
    adj[0] = e * i - f * h;
    adj[1] = c * h - b * i;
    adj[2] = b * f - c * e;
    adj[3] = f * g - d * i;
    adj[4] = a * i - c * g;
    adj[5] = c * d - a * f;
    adj[6] = d * h - e * g;
    adj[7] = b * g - a * h;
    adj[8] = a * e - b * d;
    det = a * adj[0] + b * adj[3] + c * adj[6];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      qv[k] = round_quot(adj[k] <<< (2 * FB), det);
      sat   = sat | qv[k][32];
    end
    res.r00 = qv[0][31:0]; res.r01 = qv[1][31:0]; res.r02 = qv[2][31:0];
    res.r10 = qv[3][31:0]; res.r11 = qv[4][31:0]; res.r12 = qv[5][31:0];
    res.r20 = qv[6][31:0]; res.r21 = qv[7][31:0]; res.r22 = qv[8][31:0];
    res.saturated = sat;
    return res;
  endfunction

  // one matrix transfer with random idle cycles ahead of it
  task automatic send_matrix(in_t m);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    inverse_q.push_back(predict_inverse(m));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (inverse_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_t make_matrix(int v[9]);
    in_t m;
    m.m00 = v[0]; m.m01 = v[1]; m.m02 = v[2];
    m.m10 = v[3]; m.m11 = v[4]; m.m12 = v[5];
    m.m20 = v[6]; m.m21 = v[7]; m.m22 = v[8];
    return m;
  endfunction

  function automatic int rand_span(int k);
    return int'($urandom_range(0, 2 * k)) - k;
  endfunction

  function automatic int rand_extreme();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  // random matrix: well-formed, full-range, singular, tiny and extreme ones
  function automatic in_t rand_matrix();
    int v[9];
    int kind;
    kind = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++) begin
      if (kind < 40)      v[k] = rand_span(1 << 18);
      else if (kind < 60) v[k] = $urandom;
      else if (kind < 75) v[k] = rand_span(1 << 17);
      else if (kind < 90) v[k] = rand_span(4);
      else                v[k] = rand_extreme();
    end
    // well-formed: add a diagonal boost
    if (kind < 40) begin
      v[0] += rand_span(1 << 20); v[4] += rand_span(1 << 20); v[8] += rand_span(1 << 20);
    end
    // singular by construction: a dependent row or column
    if (kind >= 60 && kind < 75) begin
      if ($urandom_range(0, 1)) begin
        v[6] = v[0] + v[3]; v[7] = v[1] + v[4]; v[8] = v[2] + v[5];
      end else begin
        v[2] = v[0]; v[5] = v[3]; v[8] = v[6];
      end
    end
    return make_matrix(v);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_t exp_r;
    out_t act_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      act_r = out_ch.data;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        exp_r = inverse_q.pop_front();
        check_field("r00", exp_r.r00, act_r.r00);
        check_field("r01", exp_r.r01, act_r.r01);
        check_field("r02", exp_r.r02, act_r.r02);
        check_field("r10", exp_r.r10, act_r.r10);
        check_field("r11", exp_r.r11, act_r.r11);
        check_field("r12", exp_r.r12, act_r.r12);
        check_field("r20", exp_r.r20, act_r.r20);
        check_field("r21", exp_r.r21, act_r.r21);
        check_field("r22", exp_r.r22, act_r.r22);
        check_field("singular", 32'(exp_r.singular), 32'(act_r.singular));
        check_field("saturated", 32'(exp_r.saturated), 32'(act_r.saturated));
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    int one;
    int mx;
    int mn;
    one = 32'sh0001_0000;
    mx  = 32'sh7fff_ffff;
    mn  = 32'sh8000_0000;
    idle_pct  = 0;
    stall_pct = 0;
    send_matrix(make_matrix('{one, 0, 0, 0, one, 0, 0, 0, one}));
    send_matrix(make_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_matrix(make_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx}));
    send_matrix(make_matrix('{mn, mn, mn, mn, mn, mn, mn, mn, mn}));
    send_matrix(make_matrix('{mx, 0, 0, 0, mx, 0, 0, 0, mx}));
    send_matrix(make_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mn}));
    send_matrix(make_matrix('{mx, mn, 0, mn, mx, mn, 0, mn, mx}));
    send_matrix(make_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_matrix(make_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, -1}));
    send_matrix(make_matrix('{-one, 0, 0, 0, -one, 0, 0, 0, -one}));
    send_matrix(make_matrix('{0, one, 0, 0, 0, one, one, 0, 0}));
    send_matrix(make_matrix('{2 * one, 0, 0, 0, 4 * one, 0, 0, 0, 3 * one}));
    send_matrix(make_matrix('{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
                              7 * one, 8 * one, 9 * one}));
    send_matrix(make_matrix('{one, 2 * one, 3 * one, 0, one, 4 * one,
                              5 * one, 6 * one, 0}));
    send_matrix(make_matrix('{3, 1, 0, 1, 3, 1, 0, 1, 3}));
    send_matrix(make_matrix('{mx, 1, 0, 1, mx, 0, 0, 0, 1}));
    send_matrix(make_matrix('{mn, mx, 1, -1, mn, mx, mx, -1, mn}));
    send_matrix(make_matrix('{one, 0, 0, 0, one, 0, 0, 0, 0}));
    wait_drained();
  endtask

  task automatic run_random(int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < RandPerPhase; n++) send_matrix(rand_matrix());
    wait_drained();
  endtask

  task automatic test_no_idle();        run_random(0, 0);   endtask
  task automatic test_sender_idle();    run_random(52, 0);  endtask
  task automatic test_receiver_stall(); run_random(0, 52);  endtask
  task automatic test_both_idle();      run_random(25, 25); endtask

  // main sequence
  initial begin
    mismatches   = 0;
    cycles       = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    stall_pct = 0;
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_in_if.sv
hw/rtl/m3i_out_if.sv
hw/rtl/m3i_div.sv
hw/rtl/matrix3x3_inverse.sv
tb/sv/tb_matrix3x3_inverse.sv
